@@ hdl/cpc_pkg.sv @@
// cpc_pkg: shared types and constants for the circular prime check unit
// no dependencies; imported by cpc_ctrl, cpc_dp and circular_prime_check_unit
`timescale 1ns / 1ps

package cpc_pkg;

    localparam int VALUE_W = 16;
    localparam int CUR_W   = 14;
    localparam int DIV_W   = 7;
    localparam int SQ_W    = 14;
    localparam int ROT_W   = 3;

    localparam logic [VALUE_W-1:0] LOW_LIMIT  = 16'd100;
    localparam logic [VALUE_W-1:0] HIGH_LIMIT = 16'd10000;
    localparam logic [VALUE_W-1:0] FOUR_DIGIT = 16'd1000;

    localparam logic [CUR_W-1:0] SCALE_3 = 14'd100;
    localparam logic [CUR_W-1:0] SCALE_4 = 14'd1000;
    localparam logic [CUR_W-1:0] SCALE_5 = 14'd10000;

    localparam logic [DIV_W-1:0] FIRST_DIV = 7'd2;
    localparam logic [SQ_W-1:0]  FIRST_SQ  = 14'd4;
    localparam logic [DIV_W-1:0] SECOND_DIV = 7'd3;
    localparam logic [SQ_W-1:0]  SECOND_SQ  = 14'd9;

    typedef struct packed {
        logic load;
        logic prime_init;
        logic rem_hi;
        logic rem_lo;
        logic rotate;
    } t_cmd;

    typedef struct packed {
        logic oor;
        logic le1;
        logic rem_zero;
        logic past_bound;
        logic last_rot;
    } t_stat;

endpackage

@@ hdl/circular_prime_check_unit.sv @@
// circular_prime_check_unit: top level, tests whether a value is a circular prime
// instantiates cpc_ctrl and cpc_dp; uses cpc_pkg
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  item in  | i_start, o_busy     | i_value[15:0]
//  result   | o_done (one cycle)  | o_is_circular_prime, o_out_of_range
//
// an item is taken when i_start is high and o_busy is low; o_done follows
// the range check when out of range; otherwise the rotations are tried in turn,
// each against trial divisors (two, then odd ones up to the root), until one fails;
// the remainder unit takes a high then a low slice, seven bits per cycle
// synchronous active-low reset clears control only; no clearing pass
// results cannot be held off; a new item may start while o_done is shown
`timescale 1ns / 1ps

module circular_prime_check_unit
    import cpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_busy,
    output logic               o_done,
    output logic               o_is_circular_prime,
    output logic               o_out_of_range
);

    t_cmd  w_cmd;
    t_stat w_stat;

    cpc_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .i_stat              (w_stat),
        .o_cmd               (w_cmd),
        .o_busy              (o_busy),
        .o_done              (o_done),
        .o_is_circular_prime (o_is_circular_prime),
        .o_out_of_range      (o_out_of_range)
    );

    cpc_dp u_dp (
        .i_clk   (i_clk),
        .i_value (i_value),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

endmodule

@@ hdl/cpc_dp.sv @@
// cpc_dp: datapath of the circular prime check unit
// holds the rotation, trial divisor, running square and remainder unit; uses cpc_pkg
`timescale 1ns / 1ps

module cpc_dp
    import cpc_pkg::*;
(
    input  logic               i_clk,
    input  logic [VALUE_W-1:0] i_value,
    input  t_cmd               i_cmd,
    output t_stat              o_stat
);

    logic [CUR_W-1:0] r_cur, n_cur;
    logic [CUR_W-1:0] r_scale, n_scale;
    logic [ROT_W-1:0] r_rot_left, n_rot_left;
    logic             r_oor, n_oor;
    logic [DIV_W-1:0] r_dv, n_dv;
    logic [SQ_W-1:0]  r_sq, n_sq;
    logic [DIV_W-1:0] r_rem, n_rem;

    logic [3:0]       w_lead;
    logic [17:0]      w_prod;
    logic [CUR_W-1:0] w_rest;
    logic [16:0]      w_rot;

    // seven restoring remainder steps on one slice of the dividend
    function automatic logic [DIV_W-1:0] rem_slice(
        input logic [DIV_W-1:0] rin,
        input logic [6:0]       bits,
        input logic [DIV_W-1:0] dv
    );
        logic [DIV_W:0] acc;
        logic [DIV_W-1:0] r;
        r = rin;
        for (int i = 6; i >= 0; i--) begin
            acc = {r, bits[i]};
            if (acc >= {1'b0, dv}) begin
                acc = acc - {1'b0, dv};
            end
            r = acc[DIV_W-1:0];
        end
        return r;
    endfunction

    // leading digit by compare against multiples of the scale
    always_comb begin
        w_lead = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if ({3'b000, r_cur} >= 17'(k) * {3'b000, r_scale}) begin
                w_lead = 4'(k);
            end
        end
        w_prod = {14'd0, w_lead} * {4'd0, r_scale};
        w_rest = r_cur - w_prod[CUR_W-1:0];
        w_rot  = {3'b000, w_rest} * 17'd10 + {13'd0, w_lead};
    end

    always_comb begin
        n_cur      = r_cur;
        n_scale    = r_scale;
        n_rot_left = r_rot_left;
        n_oor      = r_oor;
        n_dv       = r_dv;
        n_sq       = r_sq;
        n_rem      = r_rem;
        if (i_cmd.load) begin
            n_oor = (i_value < LOW_LIMIT) || (i_value > HIGH_LIMIT);
            n_cur = i_value[CUR_W-1:0];
            if (i_value >= HIGH_LIMIT) begin
                n_scale    = SCALE_5;
                n_rot_left = 3'd4;
            end else if (i_value >= FOUR_DIGIT) begin
                n_scale    = SCALE_4;
                n_rot_left = 3'd3;
            end else begin
                n_scale    = SCALE_3;
                n_rot_left = 3'd2;
            end
        end
        if (i_cmd.prime_init) begin
            n_dv  = FIRST_DIV;
            n_sq  = FIRST_SQ;
            n_rem = 7'd1;
        end
        if (i_cmd.rem_hi) begin
            n_rem = rem_slice(7'd0, r_cur[13:7], r_dv);
        end
        if (i_cmd.rem_lo) begin
            n_rem = rem_slice(r_rem, r_cur[6:0], r_dv);
            // after two only odd divisors
            if (r_dv == FIRST_DIV) begin
                n_dv = SECOND_DIV;
                n_sq = SECOND_SQ;
            end else begin
                n_dv = r_dv + 7'd2;
                n_sq = r_sq + {5'd0, r_dv, 2'b00} + 14'd4;
            end
        end
        if (i_cmd.rotate) begin
            n_cur      = w_rot[CUR_W-1:0];
            n_rot_left = r_rot_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_scale    <= n_scale;
        r_rot_left <= n_rot_left;
        r_oor      <= n_oor;
        r_dv       <= n_dv;
        r_sq       <= n_sq;
        r_rem      <= n_rem;
    end

    assign o_stat.oor        = r_oor;
    assign o_stat.le1        = (r_cur <= 14'd1);
    assign o_stat.rem_zero   = (r_rem == 7'd0);
    assign o_stat.past_bound = (r_sq > r_cur);
    assign o_stat.last_rot   = (r_rot_left == 3'd0);

endmodule

@@ hdl/cpc_ctrl.sv @@
// cpc_ctrl: controller state machine of the circular prime check unit
// sequences the datapath and registers the result; uses cpc_pkg
`timescale 1ns / 1ps

module cpc_ctrl
    import cpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done,
    output logic  o_is_circular_prime,
    output logic  o_out_of_range
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RANGE  = 7'b0000010,
        S_PINIT  = 7'b0000100,
        S_TEST   = 7'b0001000,
        S_REM_HI = 7'b0010000,
        S_REM_LO = 7'b0100000,
        S_ROTATE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;
    logic   r_pass, n_pass;
    logic   r_oor, n_oor;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_pass  = r_pass;
        n_oor   = r_oor;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RANGE;
                end
            end
            S_RANGE: begin
                if (i_stat.oor) begin
                    n_done  = 1'b1;
                    n_pass  = 1'b0;
                    n_oor   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PINIT;
                end
            end
            S_PINIT: begin
                if (i_stat.le1) begin
                    n_done  = 1'b1;
                    n_pass  = 1'b0;
                    n_oor   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.prime_init = 1'b1;
                    n_state          = S_TEST;
                end
            end
            S_TEST: begin
                if (i_stat.rem_zero) begin
                    n_done  = 1'b1;
                    n_pass  = 1'b0;
                    n_oor   = 1'b0;
                    n_state = S_IDLE;
                end else if (i_stat.past_bound) begin
                    if (i_stat.last_rot) begin
                        n_done  = 1'b1;
                        n_pass  = 1'b1;
                        n_oor   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ROTATE;
                    end
                end else begin
                    n_state = S_REM_HI;
                end
            end
            S_REM_HI: begin
                o_cmd.rem_hi = 1'b1;
                n_state      = S_REM_LO;
            end
            S_REM_LO: begin
                o_cmd.rem_lo = 1'b1;
                n_state      = S_TEST;
            end
            S_ROTATE: begin
                o_cmd.rotate = 1'b1;
                n_state      = S_PINIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_pass <= n_pass;
        r_oor  <= n_oor;
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_done              = r_done;
    assign o_is_circular_prime = r_pass;
    assign o_out_of_range      = r_oor;

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state != S_IDLE))
        else $error("result strobe without an item in work");

    a_oor_no_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_oor) |-> !r_pass)
        else $error("out-of-range item reported as circular prime");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == S_IDLE) |=> (r_state == S_RANGE))
        else $error("accepted item did not enter range check");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

endmodule
